FILE: hw/rtl/radar_measurement_jacobian_unit_assert.svh
// Assertion macros for the radar measurement Jacobian unit
`ifndef RADAR_MEASUREMENT_JACOBIAN_UNIT_ASSERT_SVH
`define RADAR_MEASUREMENT_JACOBIAN_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RMJ_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rmj assertion failed");
`define RMJ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rmj assertion failed");
`else
`define RMJ_ASSERT_IMPL(label, ante, cons)
`define RMJ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hw/rtl/rmj_pkg.sv
// Shared constants, types and saturation helper of the radar Jacobian unit
package rmj_pkg;
   localparam int FRAC_BITS  = 16;
   localparam int POS_W      = 32;
   localparam int SUM_W      = 64;
   localparam int CROSS_W    = 64;
   localparam int DEN_W      = 96;
   localparam int NUM_W      = DEN_W + FRAC_BITS;
   localparam int QUO_W      = 33;
   localparam int LANES      = 6;
   localparam int ROOT_STEPS = 32;
   localparam int DIV_STEPS  = QUO_W;

   localparam int LANE_RANGE_PX   = 0;
   localparam int LANE_RANGE_PY   = 1;
   localparam int LANE_BEARING_PX = 2;
   localparam int LANE_BEARING_PY = 3;
   localparam int LANE_RATE_PX    = 4;
   localparam int LANE_RATE_PY    = 5;

   localparam logic [SUM_W-1:0]  ROOT_ONE = SUM_W'(1) << (SUM_W - 2);
   localparam logic [31:0]       SAT_POS  = 32'h7FFF_FFFF;
   localparam logic [31:0]       SAT_NEG  = 32'h8000_0000;
   localparam logic signed [31:0] UNIT_Q  = 32'sd1 <<< FRAC_BITS;

   typedef struct packed {
      logic             valid;
      logic             zero;
      logic [LANES-1:0] neg;
   } rmj_tag_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] nlow;
      logic [DEN_W-1:0] den;
      logic [QUO_W-1:0] quo;
      logic             ovf;
   } rmj_lane_type;

   typedef rmj_lane_type [LANES-1:0] rmj_lanes_type;

   typedef struct packed {
      rmj_tag_type        tag;
      logic [POS_W-1:0]   apx;
      logic [POS_W-1:0]   apy;
      logic [SUM_W-1:0]   sum;
      logic [CROSS_W-1:0] across;
      logic [SUM_W-1:0]   rest;
      logic [SUM_W-1:0]   res;
      logic [SUM_W-1:0]   one;
   } rmj_root_type;

   typedef struct packed {
      rmj_tag_type   tag;
      rmj_lanes_type lanes;
   } rmj_div_type;

   function automatic logic [31:0] rmj_saturate(input logic [QUO_W-1:0] quo,
                                                input logic ovf, input logic neg);
      logic [31:0] r;
      if (neg) begin
         if (ovf || (quo > QUO_W'(SAT_NEG))) r = SAT_NEG;
         else r = ~quo[31:0] + 32'd1;
      end else begin
         if (ovf || (quo > QUO_W'(SAT_POS))) r = SAT_POS;
         else r = quo[31:0];
      end
      return r;
   endfunction
endpackage

FILE: hw/rtl/rmj_root_cell.sv
// One step of the integer square root chain
module rmj_root_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  rmj_pkg::rmj_root_type root_i,
   output rmj_pkg::rmj_root_type root_o
);
   import rmj_pkg::*;

   rmj_root_type root_in, root_ff;
   logic [SUM_W-1:0] cand;

   always_comb begin
      root_in = root_i;
      root_in.tag.valid = root_i.tag.valid && !reset;
      cand    = root_i.res + root_i.one;
      if (root_i.rest >= cand) begin
         root_in.rest = root_i.rest - cand;
         root_in.res  = (root_i.res >> 1) + root_i.one;
      end else begin
         root_in.res  = root_i.res >> 1;
      end
      root_in.one = root_i.one >> 2;
   end

   always_ff @(posedge clock) begin
      root_ff <= root_in;
   end

   assign root_o = root_ff;
endmodule

FILE: hw/rtl/rmj_div_cell.sv
// One quotient bit of the six restoring divider lanes
module rmj_div_cell (
   input  logic                clock,
   input  logic                reset,
   input  rmj_pkg::rmj_div_type div_i,
   output rmj_pkg::rmj_div_type div_o
);
   import rmj_pkg::*;

   rmj_div_type div_in, div_ff;
   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;

   always_comb begin
      div_in = div_i;
      div_in.tag.valid = div_i.tag.valid && !reset;
      trial  = '0;
      diff   = '0;
      for (int i = 0; i < LANES; i++) begin
         trial = {div_i.lanes[i].rem, div_i.lanes[i].nlow[QUO_W-1]};
         diff  = trial - {1'b0, div_i.lanes[i].den};
         if (trial >= {1'b0, div_i.lanes[i].den}) begin
            div_in.lanes[i].rem = diff[DEN_W-1:0];
            div_in.lanes[i].quo = {div_i.lanes[i].quo[QUO_W-2:0], 1'b1};
         end else begin
            div_in.lanes[i].rem = trial[DEN_W-1:0];
            div_in.lanes[i].quo = {div_i.lanes[i].quo[QUO_W-2:0], 1'b0};
         end
         div_in.lanes[i].nlow = div_i.lanes[i].nlow << 1;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
   end

   assign div_o = div_ff;
endmodule

FILE: hw/rtl/radar_measurement_jacobian_unit.sv
// Each start beat yields one result, strobed on rsp_valid.
// Throughput: one beat per cycle; busy stays low, every stage is a pipeline cell.
// Depth is set by the 32-cell square root chain and the 33-cell divider chain.
// Reset clears all valid bits synchronously; no results follow until new beats.
// The receiver cannot stall; results are strobed for one cycle each.
`include "radar_measurement_jacobian_unit_assert.svh"
module radar_measurement_jacobian_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_vel_x,
   input  logic [31:0] req_vel_y,
   output logic        rsp_valid,
   output logic [31:0] rsp_range_by_px,
   output logic [31:0] rsp_range_by_py,
   output logic [31:0] rsp_bearing_by_px,
   output logic [31:0] rsp_bearing_by_py,
   output logic [31:0] rsp_rate_by_px,
   output logic [31:0] rsp_rate_by_py,
   output logic        rsp_zero_range_error
);
   import rmj_pkg::*;

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // stage 1: magnitudes
   logic v1_ff, px_neg1_ff, py_neg1_ff;
   logic [POS_W-1:0] apx1_ff, apy1_ff, px1_ff, py1_ff, vx1_ff, vy1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= accept;
      px_neg1_ff <= req_pos_x[31];
      py_neg1_ff <= req_pos_y[31];
      apx1_ff    <= req_pos_x[31] ? (~req_pos_x + 32'd1) : req_pos_x;
      apy1_ff    <= req_pos_y[31] ? (~req_pos_y + 32'd1) : req_pos_y;
      px1_ff     <= req_pos_x;
      py1_ff     <= req_pos_y;
      vx1_ff     <= req_vel_x;
      vy1_ff     <= req_vel_y;
   end

   // stage 2: products
   logic v2_ff, px_neg2_ff, py_neg2_ff;
   logic [POS_W-1:0] apx2_ff, apy2_ff;
   logic [SUM_W-1:0] sqx2_ff, sqy2_ff;
   logic signed [SUM_W-1:0] m1_2_ff, m2_2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      px_neg2_ff <= px_neg1_ff;
      py_neg2_ff <= py_neg1_ff;
      apx2_ff    <= apx1_ff;
      apy2_ff    <= apy1_ff;
      sqx2_ff    <= apx1_ff * apx1_ff;
      sqy2_ff    <= apy1_ff * apy1_ff;
      m1_2_ff    <= $signed(vx1_ff) * $signed(py1_ff);
      m2_2_ff    <= $signed(vy1_ff) * $signed(px1_ff);
   end

   // stage 3: sum of squares and cross term
   logic [SUM_W:0] cross_diff;
   logic [SUM_W:0] cross_mag;
   logic           cross_neg, cross_nz, px_nz, py_nz;
   rmj_tag_type    tag3_in, tag3_ff;
   logic [SUM_W-1:0]   sum3_ff, sum3_in;
   logic [CROSS_W-1:0] across3_ff;
   logic [POS_W-1:0]   apx3_ff, apy3_ff;

   always_comb begin
      cross_diff = {m1_2_ff[SUM_W-1], m1_2_ff} - {m2_2_ff[SUM_W-1], m2_2_ff};
      cross_neg  = cross_diff[SUM_W];
      cross_nz   = |cross_diff;
      cross_mag  = cross_neg ? (~cross_diff + 1'b1) : cross_diff;
      px_nz     = |apx2_ff;
      py_nz     = |apy2_ff;
      sum3_in   = sqx2_ff + sqy2_ff;
      tag3_in.valid = v2_ff && !reset;
      tag3_in.zero  = !(px_nz || py_nz);
      tag3_in.neg[LANE_RANGE_PX]   = px_neg2_ff;
      tag3_in.neg[LANE_RANGE_PY]   = py_neg2_ff;
      tag3_in.neg[LANE_BEARING_PX] = !py_neg2_ff && py_nz;
      tag3_in.neg[LANE_BEARING_PY] = px_neg2_ff;
      tag3_in.neg[LANE_RATE_PX]    = py_neg2_ff != cross_neg;
      tag3_in.neg[LANE_RATE_PY]    = (px_neg2_ff == cross_neg) && px_nz && cross_nz;
   end

   always_ff @(posedge clock) begin
      tag3_ff    <= tag3_in;
      sum3_ff    <= sum3_in;
      across3_ff <= cross_mag[CROSS_W-1:0];
      apx3_ff    <= apx2_ff;
      apy3_ff    <= apy2_ff;
   end

   // square root chain
   rmj_root_type root_chain [ROOT_STEPS+1];

   always_comb begin
      root_chain[0].tag    = tag3_ff;
      root_chain[0].apx    = apx3_ff;
      root_chain[0].apy    = apy3_ff;
      root_chain[0].sum    = sum3_ff;
      root_chain[0].across = across3_ff;
      root_chain[0].rest   = sum3_ff;
      root_chain[0].res    = '0;
      root_chain[0].one    = ROOT_ONE;
   end

   for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
      rmj_root_cell u_cell (
         .clock (clock),
         .reset (reset),
         .root_i(root_chain[g]),
         .root_o(root_chain[g+1])
      );
   end

   rmj_root_type rt;
   assign rt = root_chain[ROOT_STEPS];

   // stage 4: partial products of the wide terms
   rmj_tag_type      tag4_ff;
   logic [POS_W-1:0] r4_ff, apx4_ff, apy4_ff;
   logic [SUM_W-1:0] sum4_ff, psr_lo4_ff, psr_hi4_ff;
   logic [SUM_W-1:0] ay_lo4_ff, ay_hi4_ff, ax_lo4_ff, ax_hi4_ff;

   always_ff @(posedge clock) begin
      if (reset) tag4_ff <= '0;
      else tag4_ff <= rt.tag;
      r4_ff      <= rt.res[POS_W-1:0];
      apx4_ff    <= rt.apx;
      apy4_ff    <= rt.apy;
      sum4_ff    <= rt.sum;
      psr_lo4_ff <= rt.sum[31:0]  * rt.res[POS_W-1:0];
      psr_hi4_ff <= rt.sum[63:32] * rt.res[POS_W-1:0];
      ay_lo4_ff  <= rt.apy * rt.across[31:0];
      ay_hi4_ff  <= rt.apy * rt.across[63:32];
      ax_lo4_ff  <= rt.apx * rt.across[31:0];
      ax_hi4_ff  <= rt.apx * rt.across[63:32];
   end

   // stage 5: numerators and denominators
   logic [DEN_W-1:0] den_c, prod_y, prod_x;
   logic [NUM_W-1:0] num5_in [LANES];
   logic [DEN_W-1:0] den5_in [LANES];
   logic [NUM_W-1:0] num5_ff [LANES];
   logic [DEN_W-1:0] den5_ff [LANES];
   rmj_tag_type      tag5_ff;

   always_comb begin
      den_c  = {32'd0, psr_lo4_ff} + {psr_hi4_ff, 32'd0};
      prod_y = {32'd0, ay_lo4_ff} + {ay_hi4_ff, 32'd0};
      prod_x = {32'd0, ax_lo4_ff} + {ax_hi4_ff, 32'd0};
      num5_in[LANE_RANGE_PX]   = NUM_W'(apx4_ff) << FRAC_BITS;
      num5_in[LANE_RANGE_PY]   = NUM_W'(apy4_ff) << FRAC_BITS;
      num5_in[LANE_BEARING_PX] = NUM_W'(apy4_ff) << (2 * FRAC_BITS);
      num5_in[LANE_BEARING_PY] = NUM_W'(apx4_ff) << (2 * FRAC_BITS);
      num5_in[LANE_RATE_PX]    = NUM_W'(prod_y) << FRAC_BITS;
      num5_in[LANE_RATE_PY]    = NUM_W'(prod_x) << FRAC_BITS;
      den5_in[LANE_RANGE_PX]   = DEN_W'(r4_ff);
      den5_in[LANE_RANGE_PY]   = DEN_W'(r4_ff);
      den5_in[LANE_BEARING_PX] = DEN_W'(sum4_ff);
      den5_in[LANE_BEARING_PY] = DEN_W'(sum4_ff);
      den5_in[LANE_RATE_PX]    = den_c;
      den5_in[LANE_RATE_PY]    = den_c;
   end

   always_ff @(posedge clock) begin
      if (reset) tag5_ff <= '0;
      else tag5_ff <= tag4_ff;
      num5_ff <= num5_in;
      den5_ff <= den5_in;
   end

   // stage 6: overflow check and divider setup
   rmj_div_type div_chain [DIV_STEPS+1];
   rmj_div_type div6_in, div6_ff;

   always_comb begin
      div6_in.tag = tag5_ff;
      div6_in.tag.valid = tag5_ff.valid && !reset;
      for (int i = 0; i < LANES; i++) begin
         div6_in.lanes[i].ovf  = (num5_ff[i] >> QUO_W) >= NUM_W'(den5_ff[i]);
         div6_in.lanes[i].rem  = DEN_W'(num5_ff[i] >> QUO_W);
         div6_in.lanes[i].nlow = num5_ff[i][QUO_W-1:0];
         div6_in.lanes[i].den  = den5_ff[i];
         div6_in.lanes[i].quo  = '0;
      end
   end

   always_ff @(posedge clock) begin
      div6_ff <= div6_in;
   end

   assign div_chain[0] = div6_ff;

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      rmj_div_cell u_cell (
         .clock(clock),
         .reset(reset),
         .div_i(div_chain[g]),
         .div_o(div_chain[g+1])
      );
   end

   rmj_div_type dq;
   assign dq = div_chain[DIV_STEPS];

   // output register
   logic        rsp_valid_ff, rsp_err_ff;
   logic [31:0] rsp_val_in [LANES];
   logic [31:0] rsp_val_ff [LANES];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         rsp_val_in[i] = dq.tag.zero ? 32'd0 :
            rmj_saturate(dq.lanes[i].quo, dq.lanes[i].ovf, dq.tag.neg[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= dq.tag.valid;
      rsp_err_ff   <= dq.tag.zero;
      rsp_val_ff   <= rsp_val_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_zero_range_error = rsp_err_ff;
   assign rsp_range_by_px      = rsp_val_ff[LANE_RANGE_PX];
   assign rsp_range_by_py      = rsp_val_ff[LANE_RANGE_PY];
   assign rsp_bearing_by_px    = rsp_val_ff[LANE_BEARING_PX];
   assign rsp_bearing_by_py    = rsp_val_ff[LANE_BEARING_PY];
   assign rsp_rate_by_px       = rsp_val_ff[LANE_RATE_PX];
   assign rsp_rate_by_py       = rsp_val_ff[LANE_RATE_PY];

   `RMJ_ASSERT_IMPL(a_zero_out, rsp_valid && rsp_zero_range_error, (rsp_range_by_px == 32'd0) && (rsp_bearing_by_py == 32'd0) && (rsp_rate_by_py == 32'd0))
   `RMJ_ASSERT_IMPL(a_root_nz, rt.tag.valid && !rt.tag.zero, rt.res != '0)
   `RMJ_ASSERT_IMPL(a_range_px, rsp_valid, ($signed(rsp_range_by_px) <= UNIT_Q) && ($signed(rsp_range_by_px) >= -UNIT_Q))
   `RMJ_ASSERT_IMPL(a_range_py, rsp_valid, ($signed(rsp_range_by_py) <= UNIT_Q) && ($signed(rsp_range_by_py) >= -UNIT_Q))
   `RMJ_ASSERT_NEXT(a_out_strobe, dq.tag.valid, rsp_valid)
endmodule
